// File: design/ir_pulse_width_frame_decoder_defines.svh
// Assertion macros shared by the IR pulse-width frame decoder checker.
// No dependencies; every macro samples on the rising edge of clock.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// Implication that holds in the same cycle, masked during reset.
`define IRPWFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication that holds in the next cycle, masked during reset.
`define IRPWFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication checked at every edge, reset included.
`define IRPWFD_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/irpwfd_pkg.sv
// Shared types and constants for the IR pulse-width frame decoder.
// No dependencies; used by the top level and the checker.
package irpwfd_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_COUNT   = 2'd1,
      STATUS_SHORT_MARK  = 2'd2,
      STATUS_SPACE_RANGE = 2'd3
   } status_type;

   // Register indexes on the CSR port
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_HDR_MARK_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HDR_SPACE_MIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HDR_SPACE_MAX = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_MARK_THR  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_END_SPACE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_ENTRIES   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ENTRIES   = 3'd6;

   // Field widths
   localparam int DUR_W   = 16;
   localparam int COUNT_W = 8;
   localparam int CODE_W  = 32;
   localparam int BITS_W  = 6;

   // Most bits collected per frame
   localparam int MAX_BITS = 32;

   // Default tick length in microseconds
   localparam int TICK_US_DEFAULT = 50;

   // Register values after reset
   localparam logic [DUR_W-1:0]   HDR_MARK_MIN_RST  = 16'd1380;
   localparam logic [DUR_W-1:0]   HDR_SPACE_MIN_RST = 16'd160;
   localparam logic [DUR_W-1:0]   HDR_SPACE_MAX_RST = 16'd480;
   localparam logic [DUR_W-1:0]   ONE_MARK_THR_RST  = 16'd660;
   localparam logic [DUR_W-1:0]   END_SPACE_RST     = 16'd840;
   localparam logic [COUNT_W-1:0] MIN_ENTRIES_RST   = 8'd16;
   localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST   = 8'd18;

endpackage

// File: design/irpwfd_req_if.sv
// Pulse input channel: valid/ready handshake carrying one pulse word.
// No dependencies.
interface irpwfd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pulse_ticks;
   logic        last_pulse;

   modport source (output valid, output pulse_ticks, output last_pulse, input ready);
   modport sink   (input valid, input pulse_ticks, input last_pulse, output ready);
endinterface

// File: design/irpwfd_rsp_if.sv
// Result channel: valid/ready handshake carrying one decoded frame word.
// No dependencies.
interface irpwfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] code_value;
   logic [5:0]  bit_count;

   modport source (output valid, output status, output code_value, output bit_count,
                   input ready);
   modport sink   (input valid, input status, input code_value, input bit_count,
                   output ready);
endinterface

// File: design/ir_pulse_width_frame_decoder.sv
// IR pulse-width frame decoder: input register, one step of decode, result register.
// The frame's last pulse word passes the input register, then the result register, before its result shows on rsp.
// One pulse word per cycle; intake stalls only while a result waits on rsp.
// Reset (synchronous, active high) clears frame state and loads register defaults.
// Depends on irpwfd_pkg, irpwfd_req_if and irpwfd_rsp_if.
module ir_pulse_width_frame_decoder #(
   parameter int TICK_US = irpwfd_pkg::TICK_US_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   irpwfd_req_if.sink                          req_ch,
   irpwfd_rsp_if.source                        rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [irpwfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [irpwfd_pkg::DUR_W-1:0]        csr_write_data
);

   localparam int DUR_W   = irpwfd_pkg::DUR_W;
   localparam int COUNT_W = irpwfd_pkg::COUNT_W;
   localparam int CODE_W  = irpwfd_pkg::CODE_W;
   localparam int BITS_W  = irpwfd_pkg::BITS_W;
   localparam int US_W    = DUR_W + $clog2(TICK_US + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration registers
   logic [DUR_W-1:0]   hdr_mark_min_ff, hdr_space_min_ff, hdr_space_max_ff;
   logic [DUR_W-1:0]   one_mark_thr_ff, end_space_ff;
   logic [COUNT_W-1:0] min_entries_ff, max_entries_ff;

   // Input register
   logic               in_valid_ff;
   logic [DUR_W-1:0]   in_ticks_ff;
   logic               in_last_ff;

   // Frame state
   logic [COUNT_W-1:0]     entry_ff, entry_in;
   logic [CODE_W-1:0]      shift_ff, shift_in;
   logic [BITS_W-1:0]      bits_ff, bits_in;
   logic                   stopped_ff, stopped_in;
   irpwfd_pkg::status_type fault_ff, fault_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   irpwfd_pkg::status_type rsp_status_ff, status_in;
   logic [CODE_W-1:0]      rsp_code_ff;
   logic [BITS_W-1:0]      rsp_bits_ff;

   logic            advance;
   logic [US_W-1:0] dur_us;

   // Decode the held word when its result, if any, has room
   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.code_value = rsp_code_ff;
   assign rsp_ch.bit_count  = rsp_bits_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_mark_min_ff  <= irpwfd_pkg::HDR_MARK_MIN_RST;
         hdr_space_min_ff <= irpwfd_pkg::HDR_SPACE_MIN_RST;
         hdr_space_max_ff <= irpwfd_pkg::HDR_SPACE_MAX_RST;
         one_mark_thr_ff  <= irpwfd_pkg::ONE_MARK_THR_RST;
         end_space_ff     <= irpwfd_pkg::END_SPACE_RST;
         min_entries_ff   <= irpwfd_pkg::MIN_ENTRIES_RST;
         max_entries_ff   <= irpwfd_pkg::MAX_ENTRIES_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            irpwfd_pkg::REG_HDR_MARK_MIN:  hdr_mark_min_ff  <= csr_write_data;
            irpwfd_pkg::REG_HDR_SPACE_MIN: hdr_space_min_ff <= csr_write_data;
            irpwfd_pkg::REG_HDR_SPACE_MAX: hdr_space_max_ff <= csr_write_data;
            irpwfd_pkg::REG_ONE_MARK_THR:  one_mark_thr_ff  <= csr_write_data;
            irpwfd_pkg::REG_END_SPACE:     end_space_ff     <= csr_write_data;
            irpwfd_pkg::REG_MIN_ENTRIES:   min_entries_ff   <= csr_write_data[COUNT_W-1:0];
            irpwfd_pkg::REG_MAX_ENTRIES:   max_entries_ff   <= csr_write_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Take a pulse word into the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_ticks_ff <= req_ch.pulse_ticks;
         in_last_ff  <= req_ch.last_pulse;
      end
   end

   // Scale ticks to microseconds
   assign dur_us = US_W'(in_ticks_ff) * US_W'(TICK_US);

   // Header checks, bit shifting, end-space stop and entry count
   always_comb begin
      fault_in   = fault_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      stopped_in = stopped_ff;
      if (entry_ff == COUNT_W'(1)) begin
         if (dur_us < US_W'(hdr_mark_min_ff)) begin
            fault_in = irpwfd_pkg::STATUS_SHORT_MARK;
         end
      end else if (entry_ff == COUNT_W'(2)) begin
         if (fault_ff == irpwfd_pkg::STATUS_OK &&
             (dur_us < US_W'(hdr_space_min_ff) || dur_us > US_W'(hdr_space_max_ff))) begin
            fault_in = irpwfd_pkg::STATUS_SPACE_RANGE;
         end
      end else if (entry_ff >= COUNT_W'(3)) begin
         if (!stopped_ff && bits_ff < BITS_W'(irpwfd_pkg::MAX_BITS)) begin
            if (entry_ff[0]) begin
               shift_in = {shift_ff[CODE_W-2:0], dur_us > US_W'(one_mark_thr_ff)};
               bits_in  = bits_ff + BITS_W'(1);
            end else if (dur_us > US_W'(end_space_ff)) begin
               stopped_in = 1'b1;
            end
         end
      end
      entry_in = (entry_ff == COUNT_MAX) ? COUNT_MAX : entry_ff + COUNT_W'(1);
   end

   // Frame status, in order of priority
   always_comb begin
      priority if (entry_in > max_entries_ff || entry_in < min_entries_ff) begin
         status_in = irpwfd_pkg::STATUS_BAD_COUNT;
      end else if (entry_in < COUNT_W'(2)) begin
         status_in = irpwfd_pkg::STATUS_SHORT_MARK;
      end else if (fault_in != irpwfd_pkg::STATUS_OK) begin
         status_in = fault_in;
      end else if (entry_in < COUNT_W'(3)) begin
         status_in = irpwfd_pkg::STATUS_SPACE_RANGE;
      end else begin
         status_in = irpwfd_pkg::STATUS_OK;
      end
   end

   // Advance frame state; drop it back to idle at the frame's last word
   always_ff @(posedge clock) begin
      if (reset || (advance && in_last_ff)) begin
         entry_ff   <= '0;
         shift_ff   <= '0;
         bits_ff    <= '0;
         stopped_ff <= 1'b0;
         fault_ff   <= irpwfd_pkg::STATUS_OK;
      end else if (advance) begin
         entry_ff   <= entry_in;
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         stopped_ff <= stopped_in;
         fault_ff   <= fault_in;
      end
   end

   // Hold a result until the sink takes it
   always_comb begin
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         rsp_status_ff <= status_in;
         rsp_code_ff   <= (status_in == irpwfd_pkg::STATUS_OK) ? shift_in : '0;
         rsp_bits_ff   <= (status_in == irpwfd_pkg::STATUS_OK) ? bits_in : '0;
      end
   end

endmodule

// File: design/irpwfd_checker.sv
// Port-level checks for the IR pulse-width frame decoder, bound to its top level.
// Depends on irpwfd_pkg and ir_pulse_width_frame_decoder_defines.svh.
`include "ir_pulse_width_frame_decoder_defines.svh"

module irpwfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_code_value,
   input logic [5:0]  rsp_bit_count
);

   // A stalled result word holds
   `IRPWFD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_code_value) && $stable(rsp_bit_count), "result word changed while stalled")

   // Errors carry no decoded bits
   `IRPWFD_ASSERT_SAME(a_err_zero, rsp_valid && rsp_status != irpwfd_pkg::STATUS_OK, rsp_code_value == 32'd0 && rsp_bit_count == 6'd0, "error result carries data")

   // Never more bits than the frame allows
   `IRPWFD_ASSERT_SAME(a_bits_max, rsp_valid, rsp_bit_count <= 6'(irpwfd_pkg::MAX_BITS), "bit count beyond limit")

   // No result right after reset
   `IRPWFD_ASSERT_ALWAYS(a_reset_idle, reset, !rsp_valid, "result valid after reset")

endmodule

bind ir_pulse_width_frame_decoder irpwfd_checker u_irpwfd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_code_value (rsp_ch.code_value),
   .rsp_bit_count  (rsp_ch.bit_count)
);
